// File: rtl/bba_pkg.sv
// Shared types and constants for the bitmap block allocator.
// Used by bba_ctrl, bba_datapath and bitmap_block_allocator_core; no dependencies.
package bba_pkg;

  localparam int unsigned FuncW  = 2;
  localparam int unsigned BlockW = 17;
  localparam int unsigned WordW  = 16;

  // Highest word index reachable by a 17-bit block number, plus one
  localparam int unsigned AddressableWords = 8192;

  localparam logic [WordW-1:0] WordFull   = 16'hffff;
  localparam logic [WordW-1:0] WordFmtLow = 16'h0007;

  typedef enum logic [FuncW-1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_MARK  = 2'd1,
    FUNC_FREE  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_DECODE = 6'b000100,
    S_SCAN   = 6'b001000,
    S_RMW    = 6'b010000,
    S_FINISH = 6'b100000
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic clr_wr;     // write format value at clear pointer
    logic load_req;   // capture incoming request
    logic scan_init;  // restart word scan
    logic scan_step;  // issue next scan read
    logic alloc_wr;   // set lowest free bit of found word
    logic rd_blk;     // read word holding the request block
    logic rmw_wr;     // write back set or cleared bit
    logic res_fail;   // result: block 0, full status
    logic res_echo;   // result: echo request block
    logic out_load;   // move result into output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic is_alloc;
    logic is_rmw;
    logic disk_ok;
    logic word_ok;
    logic found;
    logic exhausted;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/bitmap_block_allocator_core.sv
// First-fit free-block bitmap allocator, one bitmap per disk.
// Requests come in on func/disk_select/block_number with valid/ready, results leave
// as granted_block/status with valid/ready. One request is worked on at a time.
// After reset a clearing pass writes a fresh format into the bitmap RAM (blocks 0-34
// used on each disk); it writes all min(DISKS,2) * 2**clog2(BITMAP_WORDS_PER_DISK) RAM
// words (16384 at default settings), and in_ready_o stays low until it ends.
// Path from request accept to result valid, by request kind:
//   mark or free of a block inside the bitmap: decode, read the word, write it back;
//   unused func, out-of-range block, absent disk: decode only;
//   allocate: decode, then a scan that reads one RAM word per cycle through the single
//   read port up to and including the first word with a clear bit, then the bit write;
//   when no word has a clear bit, the scan reads min(BITMAP_WORDS_PER_DISK, 8192) words.
// Every path ends in a finish step that moves the result into the output register.
// A new request is taken while the previous result still sits in the output
// register. If the receiver stalls, the finished result waits inside until the
// output register frees, and the block takes no further request meanwhile.
// Depends on bba_pkg, bba_ctrl, bba_datapath and bba_ram.
module bitmap_block_allocator_core #(
  parameter int unsigned BITMAP_WORDS_PER_DISK = 8192,
  parameter int unsigned DISKS                 = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [bba_pkg::FuncW-1:0]  func_i,
  input  logic                       disk_select_i,
  input  logic [bba_pkg::BlockW-1:0] block_number_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [bba_pkg::BlockW-1:0] granted_block_o,
  output logic                       status_o
);

  bba_pkg::cmd_t cmd;
  bba_pkg::sts_t sts;

  bba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bba_datapath #(
    .BITMAP_WORDS_PER_DISK (BITMAP_WORDS_PER_DISK),
    .DISKS                 (DISKS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .func_i          (func_i),
    .disk_select_i   (disk_select_i),
    .block_number_i  (block_number_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .granted_block_o (granted_block_o),
    .status_o        (status_o)
  );

endmodule

// File: rtl/bba_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module bba_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/bba_ctrl.sv
// Sequencer for the bitmap block allocator: clearing pass, scan, read-modify-write.
// Depends on bba_pkg; drives bba_datapath through bba_pkg::cmd_t.
module bba_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bba_pkg::sts_t sts_i,
  output bba_pkg::cmd_t cmd_o
);

  bba_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bba_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == bba_pkg::S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      bba_pkg::S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = bba_pkg::S_IDLE;
        end
      end
      bba_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = bba_pkg::S_DECODE;
        end
      end
      bba_pkg::S_DECODE: begin
        if (sts_i.is_alloc && sts_i.disk_ok) begin
          cmd_o.scan_init = 1'b1;
          state_d         = bba_pkg::S_SCAN;
        end else if (sts_i.is_alloc) begin
          cmd_o.res_fail = 1'b1;
          state_d        = bba_pkg::S_FINISH;
        end else if (sts_i.is_rmw && sts_i.disk_ok && sts_i.word_ok) begin
          cmd_o.rd_blk = 1'b1;
          state_d      = bba_pkg::S_RMW;
        end else begin
          cmd_o.res_echo = 1'b1;
          state_d        = bba_pkg::S_FINISH;
        end
      end
      bba_pkg::S_SCAN: begin
        if (sts_i.found) begin
          cmd_o.alloc_wr = 1'b1;
          state_d        = bba_pkg::S_FINISH;
        end else if (sts_i.exhausted) begin
          cmd_o.res_fail = 1'b1;
          state_d        = bba_pkg::S_FINISH;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      bba_pkg::S_RMW: begin
        cmd_o.rmw_wr   = 1'b1;
        cmd_o.res_echo = 1'b1;
        state_d        = bba_pkg::S_FINISH;
      end
      bba_pkg::S_FINISH: begin
        // hold until the output register can take the result
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = bba_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bba_pkg::S_CLEAR;
      end
    endcase
  end

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("controller state not one-hot");

  a_alloc_needs_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.alloc_wr |-> sts_i.found && sts_i.is_alloc)
    else $error("allocate write without a free word");

  a_load_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("output register overwritten");

endmodule

// File: rtl/bba_datapath.sv
// Datapath of the bitmap block allocator: request registers, bitmap RAM, scan pointer,
// bit update and output register. Depends on bba_pkg and bba_ram.
module bba_datapath #(
  parameter int unsigned BITMAP_WORDS_PER_DISK = 8192,
  parameter int unsigned DISKS                 = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [bba_pkg::FuncW-1:0]    func_i,
  input  logic                         disk_select_i,
  input  logic [bba_pkg::BlockW-1:0]   block_number_i,
  input  bba_pkg::cmd_t                cmd_i,
  output bba_pkg::sts_t                sts_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [bba_pkg::BlockW-1:0]   granted_block_o,
  output logic                         status_o
);

  localparam int unsigned WordAw  = $clog2(BITMAP_WORDS_PER_DISK);
  localparam int unsigned NDisk   = (DISKS < 2) ? DISKS : 2;
  localparam int unsigned Depth   = NDisk * (1 << WordAw);
  localparam int unsigned AddrW   = $clog2(Depth);
  localparam int unsigned ScanLim = (BITMAP_WORDS_PER_DISK < bba_pkg::AddressableWords) ?
                                    BITMAP_WORDS_PER_DISK : bba_pkg::AddressableWords;
  localparam int unsigned CntW    = $clog2(ScanLim + 1);

  localparam int unsigned BlkWordW = bba_pkg::BlockW - 4;

  // Request
  logic [bba_pkg::FuncW-1:0]  req_func_q;
  logic                       req_disk_q;
  logic [bba_pkg::BlockW-1:0] req_block_q;

  // Scan and clear
  logic [CntW-1:0]   scan_cnt_q, scan_cnt_d;
  logic              pend_q, pend_d;
  logic [WordAw-1:0] pend_word_q, pend_word_d;
  logic [AddrW-1:0]  clr_cnt_q;

  // Result and output
  logic [bba_pkg::BlockW-1:0] res_block_q, res_block_d;
  logic                       res_status_q, res_status_d;
  logic                       out_valid_q;
  logic [bba_pkg::BlockW-1:0] out_block_q;
  logic                       out_status_q;

  // RAM
  logic                       ram_we, ram_re;
  logic [AddrW-1:0]           ram_waddr, ram_raddr;
  logic [bba_pkg::WordW-1:0]  ram_wdata, ram_rdata;

  logic [BlkWordW-1:0]       blk_word;
  logic [AddrW-1:0]          blk_addr, pend_addr, scan_addr;
  logic [bba_pkg::WordW-1:0] blk_mask, free_mask, fmt_word;
  logic [3:0]                free_bit;
  logic                      scan_more;

  function automatic logic [3:0] lowest_zero(input logic [bba_pkg::WordW-1:0] v);
    logic [3:0] idx;
    idx = '0;
    for (int i = bba_pkg::WordW - 1; i >= 0; i--) begin
      if (!v[i]) begin
        idx = 4'(i);
      end
    end
    return idx;
  endfunction

  assign blk_word  = req_block_q[bba_pkg::BlockW-1:4];
  assign blk_addr  = AddrW'({req_disk_q, WordAw'(blk_word)});
  assign pend_addr = AddrW'({req_disk_q, pend_word_q});
  assign scan_addr = AddrW'({req_disk_q, WordAw'(scan_cnt_q)});
  assign blk_mask  = bba_pkg::WordW'(1) << req_block_q[3:0];
  assign free_bit  = lowest_zero(ram_rdata);
  assign free_mask = bba_pkg::WordW'(1) << free_bit;
  assign scan_more = (32'(scan_cnt_q) < ScanLim);

  // Fresh format: first two words full, third word holds blocks 32 to 34
  always_comb begin
    case (32'(clr_cnt_q[WordAw-1:0]))
      32'd0, 32'd1: fmt_word = bba_pkg::WordFull;
      32'd2:        fmt_word = bba_pkg::WordFmtLow;
      default:      fmt_word = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_func_q  <= func_i;
      req_disk_q  <= disk_select_i;
      req_block_q <= block_number_i;
    end
  end

  always_comb begin
    scan_cnt_d  = scan_cnt_q;
    pend_d      = pend_q;
    pend_word_d = pend_word_q;
    if (cmd_i.scan_init) begin
      scan_cnt_d = '0;
      pend_d     = 1'b0;
    end else if (cmd_i.scan_step) begin
      pend_d      = scan_more;
      pend_word_d = WordAw'(scan_cnt_q);
      if (scan_more) begin
        scan_cnt_d = scan_cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_cnt_q <= '0;
      pend_q     <= 1'b0;
      clr_cnt_q  <= '0;
    end else begin
      scan_cnt_q <= scan_cnt_d;
      pend_q     <= pend_d;
      if (cmd_i.clr_wr) begin
        clr_cnt_q <= clr_cnt_q + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_word_q <= pend_word_d;
  end

  // RAM port selection
  always_comb begin
    ram_re    = cmd_i.rd_blk | (cmd_i.scan_step & scan_more);
    ram_raddr = cmd_i.rd_blk ? blk_addr : scan_addr;
    ram_we    = cmd_i.clr_wr | cmd_i.alloc_wr | cmd_i.rmw_wr;
    ram_waddr = clr_cnt_q;
    ram_wdata = fmt_word;
    if (cmd_i.alloc_wr) begin
      ram_waddr = pend_addr;
      ram_wdata = ram_rdata | free_mask;
    end else if (cmd_i.rmw_wr) begin
      ram_waddr = blk_addr;
      ram_wdata = (req_func_q == bba_pkg::FUNC_MARK) ? (ram_rdata | blk_mask)
                                                     : (ram_rdata & ~blk_mask);
    end
  end

  bba_ram #(
    .Width (bba_pkg::WordW),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    res_block_d  = res_block_q;
    res_status_d = res_status_q;
    if (cmd_i.alloc_wr) begin
      res_block_d  = bba_pkg::BlockW'({pend_word_q, free_bit});
      res_status_d = 1'b0;
    end else if (cmd_i.res_fail) begin
      res_block_d  = '0;
      res_status_d = 1'b1;
    end else if (cmd_i.res_echo) begin
      res_block_d  = req_block_q;
      res_status_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    res_block_q  <= res_block_d;
    res_status_q <= res_status_d;
    if (cmd_i.out_load) begin
      out_block_q  <= res_block_q;
      out_status_q <= res_status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign granted_block_o = out_block_q;
  assign status_o        = out_status_q;

  always_comb begin
    sts_o           = '0;
    sts_o.clr_last  = &clr_cnt_q;
    sts_o.is_alloc  = (req_func_q == bba_pkg::FUNC_ALLOC);
    sts_o.is_rmw    = (req_func_q == bba_pkg::FUNC_MARK) || (req_func_q == bba_pkg::FUNC_FREE);
    sts_o.disk_ok   = (32'(req_disk_q) < DISKS);
    sts_o.word_ok   = (32'(blk_word) < BITMAP_WORDS_PER_DISK);
    sts_o.found     = pend_q && (ram_rdata != bba_pkg::WordFull);
    sts_o.exhausted = !pend_q && !scan_more;
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(scan_cnt_q) <= ScanLim)
    else $error("scan pointer past last reachable word");

  a_rmw_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rmw_wr |-> $past(cmd_i.rd_blk))
    else $error("bit update without a preceding read");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=>
      out_valid_q && $stable(out_block_q) && $stable(out_status_q))
    else $error("stalled result dropped or changed");

endmodule

// File: tb/sv/bitmap_block_allocator_core_test.sv
// Self-checking test of bitmap_block_allocator_core: directed and random requests, each
// result compared against a fixed expected value or an in-bench first-fit bitmap predictor.
// Depends on bba_pkg and the bitmap_block_allocator_core RTL.
module bitmap_block_allocator_core_test;

  localparam int unsigned WORDS_PER_DISK = 8192;
  localparam int unsigned DISK_COUNT     = 2;
  localparam logic [bba_pkg::BlockW-1:0] BLK_MAX = '1;
  // Longest quiet stretch: clearing pass after reset, or a full-disk scan
  localparam int unsigned STALL_LIMIT    = 50000;
  localparam int unsigned DRAIN_CYCLES   = 50;

  typedef struct packed {
    logic [bba_pkg::BlockW-1:0] blk;
    logic                       st;
  } grant_t;

  typedef struct packed {
    bba_pkg::func_e             op;
    logic                       dsk;
    logic [bba_pkg::BlockW-1:0] blk;
    logic                       typed;
    logic [bba_pkg::BlockW-1:0] want_blk;
    logic                       want_st;
  } dir_row_t;

  logic                       clk_i          = 1'b0;
  logic                       rst_ni         = 1'b0;
  logic                       in_valid_i     = 1'b0;
  logic                       in_ready_o;
  logic [bba_pkg::FuncW-1:0]  func_i         = '0;
  logic                       disk_select_i  = 1'b0;
  logic [bba_pkg::BlockW-1:0] block_number_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i    = 1'b0;
  logic [bba_pkg::BlockW-1:0] granted_block_o;
  logic                       status_o;

  logic [bba_pkg::WordW-1:0] usage_map [DISK_COUNT][WORDS_PER_DISK];
  grant_t                    pending_grants [$];
  dir_row_t                  dir_rows [24];
  int unsigned               send_idle_pct = 0;
  int unsigned               recv_idle_pct = 0;
  int unsigned               stall_cycles  = 0;
  int unsigned               err_count     = 0;

  bitmap_block_allocator_core #(
    .BITMAP_WORDS_PER_DISK(WORDS_PER_DISK),
    .DISKS                (DISK_COUNT)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .disk_select_i  (disk_select_i),
    .block_number_i (block_number_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .granted_block_o(granted_block_o),
    .status_o       (status_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void mark_block(logic dsk, logic [bba_pkg::BlockW-1:0] blk, bit used);
    int unsigned w;
    w = blk >> 4;
    if (dsk < DISK_COUNT && w < WORDS_PER_DISK) begin
      usage_map[dsk][w][blk[3:0]] = used;
    end
  endfunction

  function automatic grant_t predict_grant(bba_pkg::func_e op, logic dsk,
                                           logic [bba_pkg::BlockW-1:0] blk);
    grant_t      g;
    int unsigned w;
    int unsigned b;
    int unsigned lim;
    bit          hit;
    g.blk = blk;
    g.st  = 1'b0;
    case (op)
      bba_pkg::FUNC_ALLOC: begin
        hit   = 1'b0;
        g.blk = '0;
        lim   = WORDS_PER_DISK < bba_pkg::AddressableWords ? WORDS_PER_DISK
                                                           : bba_pkg::AddressableWords;
        if (dsk < DISK_COUNT) begin
          for (w = 0; w < lim && !hit; w++) begin
            if (usage_map[dsk][w] != bba_pkg::WordFull) begin
              for (b = 0; b < bba_pkg::WordW && !hit; b++) begin
                if (!usage_map[dsk][w][b]) begin
                  hit   = 1'b1;
                  g.blk = bba_pkg::BlockW'(w * bba_pkg::WordW + b);
                end
              end
            end
          end
        end
        // full disk: answer block 0, which is already set
        if (!hit) g.st = 1'b1;
        mark_block(dsk, g.blk, 1'b1);
      end
      bba_pkg::FUNC_MARK: mark_block(dsk, blk, 1'b1);
      bba_pkg::FUNC_FREE: mark_block(dsk, blk, 1'b0);
      default: ;
    endcase
    return g;
  endfunction

  // Drive one request and hold it until taken; queue what it should return.
  task automatic issue_request(input bba_pkg::func_e op, input logic dsk,
                               input logic [bba_pkg::BlockW-1:0] blk,
                               input logic typed, input logic [bba_pkg::BlockW-1:0] want_blk,
                               input logic want_st);
    grant_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    func_i         <= op;
    disk_select_i  <= dsk;
    block_number_i <= blk;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    pred = predict_grant(op, dsk, blk);
    if (typed) pending_grants.push_back(grant_t'{want_blk, want_st});
    else pending_grants.push_back(pred);
  endtask

  task automatic issue_random(input int unsigned count);
    bba_pkg::func_e             op;
    int unsigned                r;
    logic [bba_pkg::BlockW-1:0] blk;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 35) op = bba_pkg::FUNC_ALLOC;
      else if (r < 60) op = bba_pkg::FUNC_MARK;
      else if (r < 90) op = bba_pkg::FUNC_FREE;
      else op = bba_pkg::FUNC_NOP;
      // mostly stay near the allocation frontier so frees open holes first-fit finds
      if ($urandom_range(99) < 70) blk = bba_pkg::BlockW'($urandom_range(255));
      else blk = bba_pkg::BlockW'($urandom_range(BLK_MAX));
      issue_request(op, 1'($urandom_range(1)), blk, 1'b0, '0, 1'b0);
    end
  endtask

  always @(posedge clk_i) begin
    grant_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (pending_grants.size() == 0) begin
        $display("%0t: unexpected result granted_block %0d status %0d",
                 $time, granted_block_o, status_o);
        err_count++;
      end else begin
        want = pending_grants.pop_front();
        if (granted_block_o !== want.blk) begin
          $display("%0t: granted_block expected %0d, got %0d", $time, want.blk, granted_block_o);
          err_count++;
        end
        if (status_o !== want.st) begin
          $display("%0t: status expected %0d, got %0d", $time, want.st, status_o);
          err_count++;
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o === 1'b1) || (out_valid_o === 1'b1 && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    for (int d = 0; d < DISK_COUNT; d++) begin
      for (int w = 0; w < WORDS_PER_DISK; w++) usage_map[d][w] = '0;
      usage_map[d][0] = bba_pkg::WordFull;
      usage_map[d][1] = bba_pkg::WordFull;
      usage_map[d][2] = bba_pkg::WordFmtLow;
    end

    // fresh format: blocks 0..34 used on both disks
    dir_rows[0]  = '{bba_pkg::FUNC_ALLOC, 1'b0, 17'd0,     1'b1, 17'd35,    1'b0};
    dir_rows[1]  = '{bba_pkg::FUNC_ALLOC, 1'b1, BLK_MAX,   1'b1, 17'd35,    1'b0};
    dir_rows[2]  = '{bba_pkg::FUNC_ALLOC, 1'b0, 17'd0,     1'b1, 17'd36,    1'b0};
    dir_rows[3]  = '{bba_pkg::FUNC_MARK,  1'b0, 17'd37,    1'b1, 17'd37,    1'b0};
    dir_rows[4]  = '{bba_pkg::FUNC_ALLOC, 1'b0, 17'd0,     1'b1, 17'd38,    1'b0};
    dir_rows[5]  = '{bba_pkg::FUNC_FREE,  1'b0, 17'd0,     1'b1, 17'd0,     1'b0};
    dir_rows[6]  = '{bba_pkg::FUNC_ALLOC, 1'b0, BLK_MAX,   1'b1, 17'd0,     1'b0};
    dir_rows[7]  = '{bba_pkg::FUNC_MARK,  1'b1, BLK_MAX,   1'b1, BLK_MAX,   1'b0};
    dir_rows[8]  = '{bba_pkg::FUNC_FREE,  1'b1, BLK_MAX,   1'b1, BLK_MAX,   1'b0};
    dir_rows[9]  = '{bba_pkg::FUNC_FREE,  1'b1, 17'd34,    1'b1, 17'd34,    1'b0};
    dir_rows[10] = '{bba_pkg::FUNC_ALLOC, 1'b1, 17'd0,     1'b1, 17'd34,    1'b0};
    dir_rows[11] = '{bba_pkg::FUNC_FREE,  1'b0, 17'd15,    1'b1, 17'd15,    1'b0};
    dir_rows[12] = '{bba_pkg::FUNC_ALLOC, 1'b0, 17'd0,     1'b1, 17'd15,    1'b0};
    dir_rows[13] = '{bba_pkg::FUNC_NOP,   1'b0, 17'h15555, 1'b1, 17'h15555, 1'b0};
    dir_rows[14] = '{bba_pkg::FUNC_NOP,   1'b1, 17'h0aaaa, 1'b1, 17'h0aaaa, 1'b0};
    dir_rows[15] = '{bba_pkg::FUNC_MARK,  1'b0, BLK_MAX,   1'b1, BLK_MAX,   1'b0};
    dir_rows[16] = '{bba_pkg::FUNC_FREE,  1'b0, BLK_MAX,   1'b1, BLK_MAX,   1'b0};
    dir_rows[17] = '{bba_pkg::FUNC_MARK,  1'b0, 17'd36,    1'b1, 17'd36,    1'b0};
    dir_rows[18] = '{bba_pkg::FUNC_FREE,  1'b0, 17'd200,   1'b1, 17'd200,   1'b0};
    dir_rows[19] = '{bba_pkg::FUNC_FREE,  1'b1, 17'd16,    1'b0, 17'd0,     1'b0};
    dir_rows[20] = '{bba_pkg::FUNC_FREE,  1'b1, 17'd47,    1'b0, 17'd0,     1'b0};
    dir_rows[21] = '{bba_pkg::FUNC_ALLOC, 1'b1, 17'd0,     1'b0, 17'd0,     1'b0};
    dir_rows[22] = '{bba_pkg::FUNC_ALLOC, 1'b1, 17'd0,     1'b0, 17'd0,     1'b0};
    dir_rows[23] = '{bba_pkg::FUNC_ALLOC, 1'b0, 17'd0,     1'b0, 17'd0,     1'b0};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 30;
    recv_idle_pct = 72;
    for (int i = 0; i < $size(dir_rows); i++) begin
      issue_request(dir_rows[i].op, dir_rows[i].dsk, dir_rows[i].blk, dir_rows[i].typed,
                    dir_rows[i].want_blk, dir_rows[i].want_st);
    end
    issue_random(25);

    send_idle_pct = 72;
    recv_idle_pct = 30;
    issue_random(25);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    issue_random(26);
    in_valid_i <= 1'b0;

    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
